/* rtl/core/page_replacement_engine_macros.svh */
// Assertion macros for the page replacement engine checker
`ifndef PAGE_REPLACEMENT_ENGINE_MACROS_SVH
`define PAGE_REPLACEMENT_ENGINE_MACROS_SVH
// implication checked every clock outside reset
`define PRE_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
// implication checked on the following clock
`define PRE_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

/* rtl/core/pre_pkg.sv */
// Shared types and constants of the page replacement engine
package pre_pkg;
	localparam int FRAMES = 64;
	localparam int FIDX_W = $clog2(FRAMES);
	localparam int FCNT_W = FIDX_W + 1;
	localparam int PAGE_BITS = 10;
	localparam int AGE_BITS = 16;
	localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
	localparam logic [1:0] POL_RANDOM = 2'd0;
	localparam logic [1:0] POL_FIFO = 2'd1;
	localparam logic [1:0] POL_CLOCK = 2'd2;
	localparam logic [1:0] POL_LRU = 2'd3;
	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_REPLACE = 2'd1;
	localparam logic [1:0] ST_UPGRADE = 2'd2;
	localparam logic [1:0] ST_ERROR = 2'd3;
	localparam logic [1:0] PROT_NONE = 2'd0;
	localparam logic [1:0] PROT_RO = 2'd1;
	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_FRAME_COUNT = 1'b1;
endpackage

/* rtl/core/page_replacement_engine.sv */
// Page replacement engine top level: sequencer over the frame table
//  channel | dir | contents
//  s_axis  | in  | tdata: page, page_prot, page_frame, random_pick
//  m_axis  | out | tdata: status, frame, evicted_page, write_back, read_page, totals
//  cfg     | in  | policy (0), frame_count (1)
// Each table entry is read, then checked or written. Errors skip the table, upgrades
// mark page_frame dirty, loads take the first free frame; if none is free, FIFO takes
// the hand, random uses random_pick mod n (n frames), clock a sweep, LRU max age and aging.
// Reset starts a clearing pass over all 64 frame table entries; input is not ready meanwhile.
// Input is also not ready while a fault is in work or a result waits for its beat.
module page_replacement_engine (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata, // page, page_prot, page_frame, random_pick
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [119:0] m_axis_tdata, // status, frame, evicted_page, write_back,
	                                   // read_page, fault_, read_, write_total
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [6:0]   cfg_wdata
);
	localparam int FW = pre_pkg::FIDX_W;
	localparam int CW = pre_pkg::FCNT_W;
	localparam int AW = pre_pkg::AGE_BITS;
	localparam int PW = pre_pkg::PAGE_BITS;
	localparam int FRAMES_V = pre_pkg::FRAMES;
	localparam int V_BIT = AW;
	localparam int D_BIT = AW + 1;
	localparam int TW = PW + AW + 2;

	typedef enum logic [3:0] {
		CLEAR, IDLE, UPG_RD, UPG_WR, FREE_RD, FREE_CHK, RMOD, CLK_RD, CLK_CHK,
		LRU_RD, LRU_CHK, AGE_RD, AGE_WR, VIC_RD, VIC_WR
	} state_t;

	state_t state_q;
	logic [1:0] policy_q;
	logic [6:0] fcount_q;
	logic [FW-1:0] hand_q, idx_q, vic_q;
	logic [AW-1:0] max_q;
	logic [31:0] faults_q, reads_q, writes_q;
	logic [PW-1:0] page_q;
	logic [FW-1:0] pf_q;
	logic [15:0] rnd_q;
	logic [4:0] bit_q;
	logic [CW:0] rem_q;
	logic [CW-1:0] n;
	logic out_full_q;
	logic [1:0] st_q;
	logic [5:0] ofr_q;
	logic [PW-1:0] oev_q;
	logic owb_q, ord_q;
	logic ram_we;
	logic [FW-1:0] ram_addr;
	logic [TW-1:0] ram_wdata;
	logic [TW-1:0] ram_rdata;
	logic [AW-1:0] rd_age;
	logic [FW-1:0] hand_v;
	logic [FW-1:0] last_idx;
	logic [FW-1:0] idx_nx;
	logic [CW:0] rem_sh;

	always_comb begin
		if (fcount_q == 7'd0) begin
			n = CW'(1);
		end else if ({1'b0, fcount_q} > 8'(FRAMES_V)) begin
			n = CW'(FRAMES_V);
		end else begin
			n = CW'(fcount_q);
		end
		last_idx = FW'(n - CW'(1));
		idx_nx = (idx_q == last_idx) ? '0 : idx_q + FW'(1);
		hand_v = (CW'(hand_q) < n) ? hand_q : '0;
		rem_sh = {rem_q[CW-1:0], rnd_q[15]};
		if (rem_sh >= (CW+1)'(n)) begin
			rem_sh = rem_sh - (CW+1)'(n);
		end
	end

	assign rd_age = ram_rdata[AW-1:0];
	assign ram_addr = (state_q == UPG_RD || state_q == UPG_WR) ? pf_q
		: ((state_q == VIC_RD || state_q == VIC_WR) ? vic_q : idx_q);

	always_comb begin
		ram_we = 1'b0;
		ram_wdata = ram_rdata;
		case (state_q)
			CLEAR: begin
				ram_we = 1'b1;
				ram_wdata = '0;
			end
			UPG_WR: begin
				ram_we = 1'b1;
				ram_wdata[D_BIT] = 1'b1;
				if (policy_q == pre_pkg::POL_CLOCK) ram_wdata[AW-1:0] = AW'(1);
				else if (policy_q == pre_pkg::POL_LRU) ram_wdata[AW-1:0] = '0;
			end
			FREE_CHK: begin
				ram_we = !ram_rdata[V_BIT];
				ram_wdata[TW-1:D_BIT+1] = page_q;
				ram_wdata[D_BIT] = 1'b0;
				ram_wdata[V_BIT] = 1'b1;
			end
			CLK_CHK: begin
				ram_we = (rd_age != '0);
				ram_wdata[AW-1:0] = '0;
			end
			AGE_WR: begin
				ram_we = 1'b1;
				if (idx_q == vic_q) begin
					ram_wdata[AW-1:0] = '0;
				end else if (rd_age != pre_pkg::AGE_MAX) begin
					ram_wdata[AW-1:0] = rd_age + AW'(1);
				end
			end
			VIC_WR: begin
				ram_we = 1'b1;
				ram_wdata[TW-1:D_BIT+1] = page_q;
				ram_wdata[D_BIT] = 1'b0;
				ram_wdata[V_BIT] = 1'b1;
				if (policy_q == pre_pkg::POL_CLOCK) ram_wdata[AW-1:0] = '0;
			end
			default: ram_we = 1'b0;
		endcase
	end

	pre_ram #(.WIDTH(TW), .DEPTH(FRAMES_V)) u_frame_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	assign s_axis_tready = (state_q == IDLE) && !out_full_q;
	assign m_axis_tvalid = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			policy_q <= pre_pkg::POL_FIFO;
			fcount_q <= 7'd64;
			hand_q <= '0;
			idx_q <= '0;
			vic_q <= '0;
			max_q <= '0;
			faults_q <= '0;
			reads_q <= '0;
			writes_q <= '0;
			page_q <= '0;
			pf_q <= '0;
			rnd_q <= '0;
			bit_q <= '0;
			rem_q <= '0;
			out_full_q <= 1'b0;
			st_q <= '0;
			ofr_q <= '0;
			oev_q <= '0;
			owb_q <= 1'b0;
			ord_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == pre_pkg::REG_POLICY) policy_q <= cfg_wdata[1:0];
				else fcount_q <= cfg_wdata;
			end
			if (out_full_q && m_axis_tready) out_full_q <= 1'b0;
			case (state_q)
				CLEAR: begin
					idx_q <= idx_q + FW'(1);
					if (idx_q == FW'(FRAMES_V - 1)) state_q <= IDLE;
				end
				IDLE: begin
					if (s_axis_tvalid && !out_full_q) begin
						page_q <= s_axis_tdata[PW-1:0];
						pf_q <= s_axis_tdata[17:12];
						rnd_q <= s_axis_tdata[33:18];
						faults_q <= faults_q + 32'd1;
						idx_q <= '0;
						oev_q <= '0;
						owb_q <= 1'b0;
						ord_q <= 1'b0;
						case (s_axis_tdata[11:10])
							pre_pkg::PROT_NONE: state_q <= FREE_RD;
							pre_pkg::PROT_RO: begin
								st_q <= pre_pkg::ST_UPGRADE;
								ofr_q <= s_axis_tdata[17:12];
								state_q <= UPG_RD;
							end
							default: begin
								st_q <= pre_pkg::ST_ERROR;
								ofr_q <= '0;
								out_full_q <= 1'b1;
							end
						endcase
					end
				end
				UPG_RD: state_q <= UPG_WR;
				UPG_WR: begin
					out_full_q <= 1'b1;
					state_q <= IDLE;
				end
				FREE_RD: state_q <= FREE_CHK;
				FREE_CHK: begin
					if (!ram_rdata[V_BIT]) begin
						st_q <= pre_pkg::ST_LOAD;
						ofr_q <= idx_q;
						ord_q <= 1'b1;
						reads_q <= reads_q + 32'd1;
						out_full_q <= 1'b1;
						state_q <= IDLE;
					end else if (idx_q == last_idx) begin
						st_q <= pre_pkg::ST_REPLACE;
						bit_q <= '0;
						rem_q <= '0;
						max_q <= '0;
						case (policy_q)
							pre_pkg::POL_RANDOM: state_q <= RMOD;
							pre_pkg::POL_FIFO: begin
								vic_q <= hand_v;
								state_q <= VIC_RD;
							end
							pre_pkg::POL_CLOCK: begin
								idx_q <= hand_v;
								state_q <= CLK_RD;
							end
							default: begin
								idx_q <= '0;
								vic_q <= '0;
								state_q <= LRU_RD;
							end
						endcase
					end else begin
						idx_q <= idx_q + FW'(1);
						state_q <= FREE_RD;
					end
				end
				RMOD: begin
					rem_q <= rem_sh;
					rnd_q <= {rnd_q[14:0], 1'b0};
					bit_q <= bit_q + 5'd1;
					if (bit_q == 5'd15) begin
						vic_q <= FW'(rem_sh);
						state_q <= VIC_RD;
					end
				end
				CLK_RD: state_q <= CLK_CHK;
				CLK_CHK: begin
					if (rd_age != '0) begin
						idx_q <= idx_nx;
						state_q <= CLK_RD;
					end else begin
						vic_q <= idx_q;
						state_q <= VIC_RD;
					end
				end
				LRU_RD: state_q <= LRU_CHK;
				LRU_CHK: begin
					if (rd_age > max_q) begin
						vic_q <= idx_q;
						max_q <= rd_age;
					end
					if (idx_q == last_idx) begin
						idx_q <= '0;
						state_q <= AGE_RD;
					end else begin
						idx_q <= idx_q + FW'(1);
						state_q <= LRU_RD;
					end
				end
				AGE_RD: state_q <= AGE_WR;
				AGE_WR: begin
					if (idx_q == last_idx) begin
						state_q <= VIC_RD;
					end else begin
						idx_q <= idx_q + FW'(1);
						state_q <= AGE_RD;
					end
				end
				VIC_RD: begin
					if (policy_q == pre_pkg::POL_FIFO || policy_q == pre_pkg::POL_CLOCK)
						hand_q <= (vic_q == last_idx) ? '0 : vic_q + FW'(1);
					state_q <= VIC_WR;
				end
				VIC_WR: begin
					oev_q <= ram_rdata[TW-1:D_BIT+1];
					owb_q <= ram_rdata[D_BIT];
					if (ram_rdata[D_BIT]) writes_q <= writes_q + 32'd1;
					reads_q <= reads_q + 32'd1;
					ofr_q <= vic_q;
					ord_q <= 1'b1;
					out_full_q <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tdata = {4'd0, writes_q, reads_q, faults_q, ord_q, owb_q, oev_q, ofr_q,
		st_q};
endmodule

/* rtl/core/pre_ram.sv */
// Generic single-port RAM with registered read
module pre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* rtl/core/pre_checker.sv */
// Port-level checker for the page replacement engine
`include "page_replacement_engine_macros.svh"
module pre_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [119:0] m_axis_tdata
);
	`PRE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`PRE_ASSERT_IMP(a_read_flag, m_axis_tvalid, m_axis_tdata[19] == !m_axis_tdata[1])
	`PRE_ASSERT_IMP(a_wb_only_replace, m_axis_tvalid && m_axis_tdata[18], m_axis_tdata[1:0] == pre_pkg::ST_REPLACE)
	`PRE_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind page_replacement_engine pre_checker u_pre_checker (.*);

/* tb/tb_page_replacement_engine.sv */
// Self-checking testbench for the page replacement engine over all replacement policies
module tb_page_replacement_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import pre_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE = 400;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  frame;
		logic [9:0]  evicted_page;
		logic        write_back;
		logic        read_page;
		logic [31:0] fault_total;
		logic [31:0] read_total;
		logic [31:0] write_total;
	} fault_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [39:0]  s_axis_tdata;  // page, page_prot, page_frame, random_pick
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [119:0] m_axis_tdata;  // status, frame, evicted_page, write_back, read_page,
	                             // fault_total, read_total, write_total
	logic         cfg_we;
	logic         cfg_index;
	logic [6:0]   cfg_wdata;

	page_replacement_engine dut (.*);

	logic [1:0]          pol_m;
	logic [6:0]          fcount_m;
	logic [PAGE_BITS-1:0] page_m [FRAMES];
	logic                valid_m [FRAMES];
	logic                dirty_m [FRAMES];
	logic [AGE_BITS-1:0] age_m [FRAMES];
	int                  hand_m;
	logic [31:0]         faults_m, reads_m, writes_m;

	fault_result_t expected_q[$];
	int mismatches = 0;
	int cycle = 0;
	int hold_until = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("** page_replacement_engine: FAILED **");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= (cycle >= hold_until) && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic fault_result_t predict_fault(logic [9:0] pg, logic [1:0] pr,
			logic [5:0] pf, logic [15:0] rp);
		fault_result_t r;
		int n, i, v, h;
		bit found;
		r = '0;
		n = (fcount_m == 0) ? 1 : (fcount_m > FRAMES) ? FRAMES : fcount_m;
		faults_m++;
		r.status = ST_ERROR;
		if (pr == PROT_NONE) begin
			found = 0;
			v = 0;
			for (i = 0; i < n && !found; i++) begin
				if (!valid_m[i]) begin
					found = 1;
					v = i;
				end
			end
			if (found) begin
				r.status = ST_LOAD;
			end else begin
				h = (hand_m < n) ? hand_m : 0;
				case (pol_m)
					POL_RANDOM: v = rp % n;
					POL_FIFO: begin
						v = h;
						hand_m = (h + 1) % n;
					end
					POL_CLOCK: begin
						v = h;
						while (age_m[v] != 0) begin
							age_m[v] = 0;
							v = (v + 1) % n;
						end
						hand_m = (v + 1) % n;
					end
					default: begin
						v = 0;
						for (i = 0; i < n; i++) if (age_m[i] > age_m[v]) v = i;
						for (i = 0; i < n; i++) begin
							if (i == v) age_m[i] = 0;
							else if (age_m[i] != AGE_MAX) age_m[i]++;
						end
					end
				endcase
				r.status = ST_REPLACE;
				r.evicted_page = page_m[v];
				r.write_back = dirty_m[v];
				if (dirty_m[v]) writes_m++;
				if (pol_m == POL_CLOCK) age_m[v] = 0;
			end
			page_m[v] = pg;
			valid_m[v] = 1;
			dirty_m[v] = 0;
			r.frame = 6'(v);
			r.read_page = 1;
			reads_m++;
		end else if (pr == PROT_RO) begin
			dirty_m[pf] = 1;
			if (pol_m == POL_CLOCK) age_m[pf] = 1;
			else if (pol_m == POL_LRU) age_m[pf] = 0;
			r.status = ST_UPGRADE;
			r.frame = pf;
		end
		r.fault_total = faults_m;
		r.read_total = reads_m;
		r.write_total = writes_m;
		return r;
	endfunction

	task automatic note_mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d, got %0d at cycle %0d", field, exp_v, act_v, cycle);
	endtask

	always @(negedge clk) begin
		fault_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tdata[1:0];
			got.frame = m_axis_tdata[7:2];
			got.evicted_page = m_axis_tdata[17:8];
			got.write_back = m_axis_tdata[18];
			got.read_page = m_axis_tdata[19];
			got.fault_total = m_axis_tdata[51:20];
			got.read_total = m_axis_tdata[83:52];
			got.write_total = m_axis_tdata[115:84];
			if (expected_q.size() == 0) begin
				note_mismatch("unexpected beat", 0, 1);
			end else begin
				want = expected_q.pop_front();
				if (got.status != want.status) note_mismatch("status", want.status, got.status);
				if (got.frame != want.frame) note_mismatch("frame", want.frame, got.frame);
				if (got.evicted_page != want.evicted_page)
					note_mismatch("evicted_page", want.evicted_page, got.evicted_page);
				if (got.write_back != want.write_back)
					note_mismatch("write_back", want.write_back, got.write_back);
				if (got.read_page != want.read_page)
					note_mismatch("read_page", want.read_page, got.read_page);
				if (got.fault_total != want.fault_total)
					note_mismatch("fault_total", want.fault_total, got.fault_total);
				if (got.read_total != want.read_total)
					note_mismatch("read_total", want.read_total, got.read_total);
				if (got.write_total != want.write_total)
					note_mismatch("write_total", want.write_total, got.write_total);
			end
		end
	end

	task automatic send_fault(logic [9:0] pg, logic [1:0] pr, logic [5:0] pf, logic [15:0] rp);
		bit taken;
		taken = 0;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, rp, pf, pr, pg};
		while (!taken) begin
			@(negedge clk);
			taken = s_axis_tready;
			if (taken) expected_q.push_back(predict_fault(pg, pr, pf, rp));
			@(posedge clk);
		end
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [6:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_POLICY) pol_m = val[1:0];
		else fcount_m = val;
		@(posedge clk);
	endtask

	task automatic configure(logic [1:0] pol, logic [6:0] fc);
		drain();
		write_reg(REG_POLICY, {5'd0, pol});
		write_reg(REG_FRAME_COUNT, fc);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed;
		send_fault(10'd0, PROT_NONE, 6'd0, 16'd0);
		send_fault(10'h3FF, PROT_NONE, 6'd0, 16'hFFFF);
		send_fault(10'd5, PROT_RO, 6'd0, 16'd0);
		send_fault(10'd6, PROT_RO, 6'd63, 16'd0);
		send_fault(10'd7, 2'd2, 6'h3F, 16'd0);
		send_fault(10'd8, 2'd3, 6'h2A, 16'h5555);
		configure(POL_CLOCK, 7'd2);
		send_fault(10'h155, PROT_NONE, 6'd0, 16'd0);
		send_fault(10'h2AA, PROT_RO, 6'd0, 16'd0);
		send_fault(10'd100, PROT_NONE, 6'd0, 16'd0);
		send_fault(10'd101, PROT_NONE, 6'd0, 16'd0);
		configure(POL_RANDOM, 7'd3);
		send_fault(10'd200, PROT_NONE, 6'd0, 16'hFFFF);
		send_fault(10'd201, PROT_NONE, 6'd0, 16'd0);
		send_fault(10'd202, PROT_NONE, 6'd0, 16'd7);
		configure(POL_LRU, 7'd3);
		send_fault(10'd300, PROT_RO, 6'd1, 16'd0);
		send_fault(10'd301, PROT_NONE, 6'd0, 16'd0);
		send_fault(10'd302, PROT_NONE, 6'd0, 16'd0);
		configure(POL_FIFO, 7'd0);
		send_fault(10'd400, PROT_NONE, 6'd0, 16'd0);
		send_fault(10'd401, PROT_NONE, 6'd0, 16'd0);
		configure(POL_FIFO, 7'd100);
		send_fault(10'd402, PROT_NONE, 6'd0, 16'd0);
	endtask

	task automatic test_policy(logic [1:0] pol, logic [6:0] fc, int count);
		int k, sel, span;
		logic [1:0] pr;
		configure(pol, fc);
		span = (fc == 0) ? 1 : (fc > FRAMES) ? FRAMES : fc;
		for (k = 0; k < count; k++) begin
			sel = $urandom_range(99);
			pr = (sel < 65) ? PROT_NONE : (sel < 90) ? PROT_RO : 2'($urandom_range(2, 3));
			send_fault(10'($urandom), pr,
				($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(span - 1)),
				16'($urandom));
		end
	endtask

	task automatic test_backpressure;
		configure(POL_FIFO, 7'd4);
		hold_until = cycle + 3000;
		repeat (20) send_fault(10'($urandom), PROT_NONE, 6'd0, 16'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_POLICY;
		cfg_wdata = '0;
		pol_m = POL_FIFO;
		fcount_m = 7'd64;
		for (int i = 0; i < FRAMES; i++) begin
			page_m[i] = '0;
			valid_m[i] = 0;
			dirty_m[i] = 0;
			age_m[i] = '0;
		end
		hand_m = 0;
		faults_m = 0;
		reads_m = 0;
		writes_m = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 14;
		rx_idle_pct = 65;
		test_directed();
		test_policy(POL_RANDOM, 7'd4, 110);
		test_policy(POL_FIFO, 7'd7, 110);
		test_policy(POL_CLOCK, 7'd5, 110);
		tx_idle_pct = 65;
		rx_idle_pct = 14;
		test_policy(POL_LRU, 7'd6, 110);
		test_policy(POL_CLOCK, 7'd64, 110);
		test_policy(POL_LRU, 7'd64, 90);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_policy(POL_FIFO, 7'd1, 60);
		test_policy(POL_RANDOM, 7'd0, 40);
		test_policy(POL_LRU, 7'd100, 80);
		test_backpressure();

		drain();
		if (mismatches == 0) begin
			$display("** page_replacement_engine: PASSED **");
		end else begin
			$display("** page_replacement_engine: FAILED **");
		end
		$finish;
	end
endmodule
